// ===== design/mnp_pkg.sv =====
// shared types and constants for the masked next permutation block
// used by mnp_ctrl, mnp_datapath and masked_next_permutation; no dependencies
package mnp_pkg;

  localparam int VAL_W   = 8;
  localparam int POS_W   = 4;
  localparam int LEN_W   = 5;
  localparam int TDATA_W = 16;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIV,
    ST_SWP,
    ST_SWAP2,
    ST_RA,
    ST_RB,
    ST_RW,
    ST_EMIT,
    ST_EXH
  } state_t;

  // datapath commands, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PIV_START,
    OP_PIV_STEP,
    OP_PIV_HIT,
    OP_SWP_STEP,
    OP_SWP_HIT,
    OP_SWAP2,
    OP_RA_STEP,
    OP_RA_HIT,
    OP_RB_STEP,
    OP_RB_HIT,
    OP_RW,
    OP_EMIT_START,
    OP_EMIT_STEP,
    OP_EXH
  } dp_op_t;

  typedef struct packed {
    logic n_zero;
    logic cur_zero;
    logic mov;
    logic piv_hit;
    logic gt_piv;
    logic a_ge_b;
    logic b_le_a;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

// ===== design/masked_next_permutation.sv =====
// top level of the masked next permutation block
// depends on mnp_pkg, mnp_datapath and mnp_ctrl
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid / s_tready  s_tuser cmd, s_tdata position, entry_value
// m_*      out  m_tvalid / m_tready  m_tuser exhausted, m_tlast last,
//                                     m_tdata out_position, out_value
// cfg_*    in   cfg_valid/cfg_ready  cfg_data length
//
// a load is written on its accept; an advance passes through its accept, a pivot scan
// over the entries, a scan for the swap partner, the swap finish, a skip over fixed
// entries, the swap of each reversed pair and the close of the reversal, then the
// results, one per cycle while m_tready is high; one store read per cycle
// a no-pivot advance ends after the pivot scan, or at length 0 without a scan, with one exhausted result
// rst is synchronous, store reads all zero, length 16; a stalled result holds the
// output register and the sequencer waits on it
module masked_next_permutation #(
  parameter int MAX_LEN = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic                         s_tuser,   // [0] cmd
  input  logic [mnp_pkg::TDATA_W-1:0]  s_tdata,   // [3:0] position, [11:4] entry_value
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic                         m_tuser,   // [0] exhausted
  output logic                         m_tlast,
  output logic [mnp_pkg::TDATA_W-1:0]  m_tdata,   // [3:0] out_position, [11:4] out_value
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mnp_pkg::LEN_W-1:0]    cfg_data
);

  mnp_pkg::status_t status;
  mnp_pkg::dp_op_t  op;

  assign cfg_ready = 1'b1;

  mnp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .op       (op)
  );

  mnp_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .op        (op),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // an exhausted result is a lone, last, all-zero transfer
  a_exh_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("exhausted result malformed");

  // a new result only comes from an emit or exhausted command
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(op) == mnp_pkg::OP_EMIT_STEP) ||
                        ($past(op) == mnp_pkg::OP_EXH))
    else $error("output loaded without a command");

  // store writes from the input only on an accepted load
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    op == mnp_pkg::OP_LOAD |-> s_tvalid && s_tready && (s_tuser == mnp_pkg::CMD_LOAD))
    else $error("load without accepted transfer");

  // no result is overwritten while stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> (op != mnp_pkg::OP_EMIT_STEP) && (op != mnp_pkg::OP_EXH))
    else $error("result overwritten while stalled");

endmodule

// ===== design/mnp_datapath.sv =====
// entry store, scan cursors, pivot/swap registers and output register
// depends on mnp_pkg; driven by commands from mnp_ctrl
module mnp_datapath #(
  parameter int MAX_LEN = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [mnp_pkg::LEN_W-1:0]    cfg_data,
  input  logic [mnp_pkg::TDATA_W-1:0]  s_tdata,
  input  mnp_pkg::dp_op_t              op,
  output mnp_pkg::status_t             status,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [mnp_pkg::TDATA_W-1:0]  m_tdata,
  output logic                         m_tuser,
  output logic                         m_tlast
);

  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int NW = $clog2(MAX_LEN + 1);

  logic [mnp_pkg::LEN_W-1:0] length;

  logic signed [mnp_pkg::VAL_W-1:0] mem [MAX_LEN];
  logic [MAX_LEN-1:0]               vbit;
  logic signed [mnp_pkg::VAL_W-1:0] rd_data;
  logic                             rd_vld;

  logic                             wr_en;
  logic [IW-1:0]                    wr_addr;
  logic signed [mnp_pkg::VAL_W-1:0] wr_data;
  logic                             rd_en;
  logic [IW-1:0]                    rd_addr;

  logic [NW-1:0]                    n_used;
  logic [IW-1:0]                    n_m1;
  logic signed [mnp_pkg::VAL_W-1:0] ent;

  logic [IW-1:0]                    cur;
  logic                             seen;
  logic signed [mnp_pkg::VAL_W-1:0] nxt_val;
  logic [IW-1:0]                    piv_idx;
  logic signed [mnp_pkg::VAL_W-1:0] piv_val;
  logic signed [mnp_pkg::VAL_W-1:0] swp_val;
  logic [IW-1:0]                    a_idx;
  logic [IW-1:0]                    b_idx;
  logic signed [mnp_pkg::VAL_W-1:0] a_val;
  logic [IW-1:0]                    emit_idx;

  logic [mnp_pkg::POS_W-1:0]        out_position;
  logic signed [mnp_pkg::VAL_W-1:0] out_value;
  logic                             out_free;

  logic [mnp_pkg::POS_W-1:0]        in_position;
  logic signed [mnp_pkg::VAL_W-1:0] in_value;
  logic                             pos_ok;

  assign in_position = s_tdata[mnp_pkg::POS_W-1:0];
  assign in_value    = s_tdata[mnp_pkg::POS_W+mnp_pkg::VAL_W-1:mnp_pkg::POS_W];
  assign pos_ok      = (32'(in_position) < MAX_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= mnp_pkg::LEN_RESET;
    end else if (cfg_valid) begin
      length <= cfg_data;
    end
  end

  always_comb begin
    if (32'(length) > MAX_LEN) begin
      n_used = NW'(MAX_LEN);
    end else begin
      n_used = NW'(length);
    end
  end

  assign n_m1     = IW'(n_used - NW'(1));
  assign ent      = rd_vld ? rd_data : '0;
  assign out_free = !m_tvalid || m_tready;

  // store port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = piv_val;
    rd_en   = 1'b0;
    rd_addr = cur;
    unique case (op) inside
      mnp_pkg::OP_LOAD: begin
        wr_en   = pos_ok;
        wr_addr = IW'(in_position);
        wr_data = in_value;
      end
      mnp_pkg::OP_PIV_START, mnp_pkg::OP_PIV_HIT: begin
        rd_en   = 1'b1;
        rd_addr = n_m1;
      end
      mnp_pkg::OP_PIV_STEP, mnp_pkg::OP_SWP_STEP: begin
        rd_en   = 1'b1;
        rd_addr = cur - IW'(1);
      end
      mnp_pkg::OP_SWP_HIT: begin
        wr_en   = 1'b1;
        wr_addr = cur;
        wr_data = piv_val;
      end
      mnp_pkg::OP_SWAP2: begin
        wr_en   = 1'b1;
        wr_addr = piv_idx;
        wr_data = swp_val;
        rd_en   = 1'b1;
        rd_addr = piv_idx + IW'(1);
      end
      mnp_pkg::OP_RA_STEP: begin
        rd_en   = 1'b1;
        rd_addr = a_idx + IW'(1);
      end
      mnp_pkg::OP_RA_HIT: begin
        rd_en   = 1'b1;
        rd_addr = b_idx;
      end
      mnp_pkg::OP_RB_STEP: begin
        rd_en   = 1'b1;
        rd_addr = b_idx - IW'(1);
      end
      mnp_pkg::OP_RB_HIT: begin
        wr_en   = 1'b1;
        wr_addr = a_idx;
        wr_data = ent;
      end
      mnp_pkg::OP_RW: begin
        // read of a+1 may hit b only when the reversal is already done
        wr_en   = 1'b1;
        wr_addr = b_idx;
        wr_data = a_val;
        rd_en   = 1'b1;
        rd_addr = a_idx + IW'(1);
      end
      mnp_pkg::OP_EMIT_START: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      mnp_pkg::OP_EMIT_STEP: begin
        rd_en   = (emit_idx != n_m1);
        rd_addr = emit_idx + IW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit   <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vbit[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vbit[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      mnp_pkg::OP_PIV_START: begin
        cur  <= n_m1;
        seen <= 1'b0;
      end
      mnp_pkg::OP_PIV_STEP: begin
        if (ent > 0) begin
          seen    <= 1'b1;
          nxt_val <= ent;
        end
        cur <= cur - IW'(1);
      end
      mnp_pkg::OP_PIV_HIT: begin
        piv_idx <= cur;
        piv_val <= ent;
        cur     <= n_m1;
      end
      mnp_pkg::OP_SWP_STEP: cur <= cur - IW'(1);
      mnp_pkg::OP_SWP_HIT:  swp_val <= ent;
      mnp_pkg::OP_SWAP2: begin
        a_idx <= piv_idx + IW'(1);
        b_idx <= n_m1;
      end
      mnp_pkg::OP_RA_STEP: a_idx <= a_idx + IW'(1);
      mnp_pkg::OP_RA_HIT:  a_val <= ent;
      mnp_pkg::OP_RB_STEP: b_idx <= b_idx - IW'(1);
      mnp_pkg::OP_RW: begin
        a_idx <= a_idx + IW'(1);
        b_idx <= b_idx - IW'(1);
      end
      mnp_pkg::OP_EMIT_START: emit_idx <= '0;
      mnp_pkg::OP_EMIT_STEP:  emit_idx <= emit_idx + IW'(1);
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (op == mnp_pkg::OP_EMIT_STEP || op == mnp_pkg::OP_EXH) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == mnp_pkg::OP_EMIT_STEP) begin
      out_position <= mnp_pkg::POS_W'(emit_idx);
      out_value    <= ent;
      m_tuser      <= 1'b0;
      m_tlast      <= (emit_idx == n_m1);
    end else if (op == mnp_pkg::OP_EXH) begin
      out_position <= '0;
      out_value    <= '0;
      m_tuser      <= 1'b1;
      m_tlast      <= 1'b1;
    end
  end

  assign m_tdata = {(mnp_pkg::TDATA_W - mnp_pkg::POS_W - mnp_pkg::VAL_W)'(0),
                    out_value, out_position};

  assign status.n_zero    = (n_used == '0);
  assign status.cur_zero  = (cur == '0);
  assign status.mov       = (ent > 0);
  assign status.piv_hit   = (ent > 0) && seen && (ent < nxt_val);
  assign status.gt_piv    = (ent > piv_val);
  assign status.a_ge_b    = (a_idx >= b_idx);
  assign status.b_le_a    = (b_idx <= a_idx);
  assign status.emit_last = (emit_idx == n_m1);
  assign status.out_free  = out_free;

endmodule

// ===== design/mnp_ctrl.sv =====
// sequencer: loads, pivot scan, swap scan, reversal and emission of the arrangement or of an exhausted result;
// depends on mnp_pkg; issues one datapath command per cycle, OP_NONE while it waits on a stalled output
module mnp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tuser,
  output logic             s_tready,
  input  mnp_pkg::status_t status,
  output mnp_pkg::dp_op_t  op
);

  mnp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = mnp_pkg::OP_NONE;
    s_tready   = 1'b0;
    unique case (state)
      mnp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == mnp_pkg::CMD_LOAD) begin
            op = mnp_pkg::OP_LOAD;
          end else if (status.n_zero) begin
            state_next = mnp_pkg::ST_EXH;
          end else begin
            op         = mnp_pkg::OP_PIV_START;
            state_next = mnp_pkg::ST_PIV;
          end
        end
      end
      mnp_pkg::ST_PIV: begin
        if (status.piv_hit) begin
          op         = mnp_pkg::OP_PIV_HIT;
          state_next = mnp_pkg::ST_SWP;
        end else if (status.cur_zero) begin
          state_next = mnp_pkg::ST_EXH;
        end else begin
          op = mnp_pkg::OP_PIV_STEP;
        end
      end
      mnp_pkg::ST_SWP: begin
        // the movable entry right of the pivot always qualifies
        if (status.gt_piv) begin
          op         = mnp_pkg::OP_SWP_HIT;
          state_next = mnp_pkg::ST_SWAP2;
        end else begin
          op = mnp_pkg::OP_SWP_STEP;
        end
      end
      mnp_pkg::ST_SWAP2: begin
        op         = mnp_pkg::OP_SWAP2;
        state_next = mnp_pkg::ST_RA;
      end
      mnp_pkg::ST_RA: begin
        if (status.a_ge_b) begin
          op         = mnp_pkg::OP_EMIT_START;
          state_next = mnp_pkg::ST_EMIT;
        end else if (status.mov) begin
          op         = mnp_pkg::OP_RA_HIT;
          state_next = mnp_pkg::ST_RB;
        end else begin
          op = mnp_pkg::OP_RA_STEP;
        end
      end
      mnp_pkg::ST_RB: begin
        if (status.b_le_a) begin
          op         = mnp_pkg::OP_EMIT_START;
          state_next = mnp_pkg::ST_EMIT;
        end else if (status.mov) begin
          op         = mnp_pkg::OP_RB_HIT;
          state_next = mnp_pkg::ST_RW;
        end else begin
          op = mnp_pkg::OP_RB_STEP;
        end
      end
      mnp_pkg::ST_RW: begin
        op         = mnp_pkg::OP_RW;
        state_next = mnp_pkg::ST_RA;
      end
      mnp_pkg::ST_EMIT: begin
        if (status.out_free) begin
          op = mnp_pkg::OP_EMIT_STEP;
          if (status.emit_last) begin
            state_next = mnp_pkg::ST_IDLE;
          end
        end
      end
      mnp_pkg::ST_EXH: begin
        if (status.out_free) begin
          op         = mnp_pkg::OP_EXH;
          state_next = mnp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mnp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
